[rtl/ffra_pkg.sv]
// shared types, codes and microprogram of the first-fit region allocator
`default_nettype none
package ffra_pkg;

	localparam int unsigned SIZE_BITS  = 22;
	localparam int unsigned LIMIT_BITS = 22;
	localparam int unsigned RID_BITS   = 5;
	localparam int unsigned STAT_BITS  = 3;

	typedef logic [STAT_BITS-1:0] status_t;

	// result codes
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_BAD_SLOT = 3'd1;
	localparam status_t ST_LIMIT    = 3'd2;
	localparam status_t ST_EMPTY    = 3'd3;
	localparam status_t ST_FULL     = 3'd4;

	// request codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// datapath actions, one per control word
	typedef enum logic [3:0] {
		A_NOP,
		A_ACCEPT,
		A_LOAD_SLOT,
		A_HOLE_RD,
		A_HOLE_LOAD,
		A_GRANT_HOLE,
		A_SPLIT,
		A_SHIFT_RD,
		A_SHIFT_WR,
		A_DROP,
		A_LIMIT,
		A_GROW,
		A_EMPTY,
		A_FULL,
		A_PUSH,
		A_EMIT
	} dp_op_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_REQ,
		C_BAD_SLOT,
		C_FREE,
		C_K_ZERO,
		C_NO_FIT,
		C_EXACT,
		C_SH_END,
		C_OVER,
		C_EMPTY,
		C_FULL,
		C_OUT_BUSY
	} cond_t;

	typedef logic [4:0] step_t;

	typedef struct packed {
		dp_op_t op;
		cond_t  cond;
		step_t  target;
	} uword_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic no_req;
		logic bad_slot;
		logic is_free;
		logic k_zero;
		logic no_fit;
		logic exact;
		logic sh_end;
		logic over;
		logic empty;
		logic full;
		logic out_busy;
	} flags_t;

	// step labels
	localparam step_t S_IDLE  = 5'd0;
	localparam step_t S_CHK   = 5'd1;
	localparam step_t S_BR    = 5'd2;
	localparam step_t S_SRCH  = 5'd3;
	localparam step_t S_HLD   = 5'd4;
	localparam step_t S_FIT   = 5'd5;
	localparam step_t S_GNT   = 5'd6;
	localparam step_t S_SPL   = 5'd7;
	localparam step_t S_SHT   = 5'd8;
	localparam step_t S_SHW   = 5'd9;
	localparam step_t S_DROP  = 5'd10;
	localparam step_t S_BRK   = 5'd11;
	localparam step_t S_GROW  = 5'd12;
	localparam step_t S_FCHK  = 5'd13;
	localparam step_t S_FFUL  = 5'd14;
	localparam step_t S_PUSH  = 5'd15;
	localparam step_t S_EMIT  = 5'd16;
	localparam step_t S_RET   = 5'd17;

	// control store
	function automatic uword_t ffra_ucode(step_t s);
		uword_t w;
		unique case (s)
			S_IDLE: w = '{A_ACCEPT,     C_NO_REQ,   S_IDLE};
			S_CHK:  w = '{A_LOAD_SLOT,  C_BAD_SLOT, S_EMIT};
			S_BR:   w = '{A_NOP,        C_FREE,     S_FCHK};
			S_SRCH: w = '{A_HOLE_RD,    C_K_ZERO,   S_BRK};
			S_HLD:  w = '{A_HOLE_LOAD,  C_NEXT,     S_IDLE};
			S_FIT:  w = '{A_NOP,        C_NO_FIT,   S_SRCH};
			S_GNT:  w = '{A_GRANT_HOLE, C_EXACT,    S_SHT};
			S_SPL:  w = '{A_SPLIT,      C_ALWAYS,   S_EMIT};
			S_SHT:  w = '{A_SHIFT_RD,   C_SH_END,   S_DROP};
			S_SHW:  w = '{A_SHIFT_WR,   C_ALWAYS,   S_SHT};
			S_DROP: w = '{A_DROP,       C_ALWAYS,   S_EMIT};
			S_BRK:  w = '{A_LIMIT,      C_OVER,     S_EMIT};
			S_GROW: w = '{A_GROW,       C_ALWAYS,   S_EMIT};
			S_FCHK: w = '{A_EMPTY,      C_EMPTY,    S_EMIT};
			S_FFUL: w = '{A_FULL,       C_FULL,     S_EMIT};
			S_PUSH: w = '{A_PUSH,       C_NEXT,     S_IDLE};
			S_EMIT: w = '{A_EMIT,       C_OUT_BUSY, S_EMIT};
			S_RET:  w = '{A_NOP,        C_ALWAYS,   S_IDLE};
			default: w = '{A_NOP,       C_ALWAYS,   S_IDLE};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

[rtl/first_fit_region_allocator_top.sv]
// top level of the first-fit region allocator
// Takes one alloc or free request at a time and answers each with exactly one
// result beat (status, addr). An alloc walks the free list newest hole first
// and takes the first hole that is long enough, splitting it or removing it on
// an exact fit; with no fitting hole the break pointer grows up to heap_limit.
// A free pushes the slot's region as the newest hole and empties the slot;
// an empty slot or a full hole list is answered with an error status instead.
// Holes are never merged. Control is a small microprogram stepping a plain
// datapath, and every hole access goes through the single read port of the
// hole list ram. A bad slot id is answered with an error status and nothing
// else changes; an exact fit moves every newer hole down one place. The
// output register holds the result while stalled, and the next request is
// accepted once the sequencer is back in its idle step.
// Slot contents come out of reset empty through per-slot valid flags, so no
// clearing pass is needed; heap_limit resets to all ones.
`default_nettype none
module first_fit_region_allocator_top #(
	parameter int unsigned SLOTS     = 32,
	parameter int unsigned HOLES     = 32,
	parameter int unsigned ADDR_BITS = 22
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// heap_limit register write
	input  wire logic                            cfg_we,
	input  wire logic [ffra_pkg::LIMIT_BITS-1:0] cfg_wdata,
	// request channel
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire logic                            cmd,
	input  wire logic [ffra_pkg::RID_BITS-1:0]   region_id,
	input  wire logic [ffra_pkg::SIZE_BITS-1:0]  size,
	// result channel
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output logic [ffra_pkg::STAT_BITS-1:0]       status,
	output logic [ADDR_BITS-1:0]                 addr
);
	import ffra_pkg::*;

	// action of the current microstep and the datapath conditions it tests
	dp_op_t op;
	flags_t flags;

	ffra_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.op     (op)
	);

	ffra_dp #(
		.SLOTS     (SLOTS),
		.HOLES     (HOLES),
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.flags     (flags),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.region_id (region_id),
		.size      (size),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.addr      (addr)
	);
endmodule
`default_nettype wire

[rtl/ffra_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module ffra_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

[rtl/ffra_useq.sv]
// microcode sequencer: step counter, control store and jump logic
`default_nettype none
module ffra_useq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ffra_pkg::flags_t flags,
	output ffra_pkg::dp_op_t      op
);
	import ffra_pkg::*;

	step_t  upc_q;
	step_t  upc_d;
	uword_t word;
	logic   jump;

	assign word = ffra_ucode(upc_q);
	assign op   = word.op;

	always_comb begin
		unique case (word.cond)
			C_NEXT:     jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_REQ:   jump = flags.no_req;
			C_BAD_SLOT: jump = flags.bad_slot;
			C_FREE:     jump = flags.is_free;
			C_K_ZERO:   jump = flags.k_zero;
			C_NO_FIT:   jump = flags.no_fit;
			C_EXACT:    jump = flags.exact;
			C_SH_END:   jump = flags.sh_end;
			C_OVER:     jump = flags.over;
			C_EMPTY:    jump = flags.empty;
			C_FULL:     jump = flags.full;
			C_OUT_BUSY: jump = flags.out_busy;
			default:    jump = 1'b1;
		endcase
	end

	always_comb begin
		upc_d = jump ? word.target : step_t'(upc_q + step_t'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end
endmodule
`default_nettype wire

[rtl/ffra_dp.sv]
// allocator datapath: slot table, hole list, break pointer and result register
`default_nettype none
module ffra_dp #(
	parameter int unsigned SLOTS     = 32,
	parameter int unsigned HOLES     = 32,
	parameter int unsigned ADDR_BITS = 22
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ffra_pkg::dp_op_t                 op,
	output ffra_pkg::flags_t                      flags,
	input  wire logic                             cfg_we,
	input  wire logic [ffra_pkg::LIMIT_BITS-1:0]  cfg_wdata,
	input  wire logic                             req_valid,
	output logic                                  req_stall,
	input  wire logic                             cmd,
	input  wire logic [ffra_pkg::RID_BITS-1:0]    region_id,
	input  wire logic [ffra_pkg::SIZE_BITS-1:0]   size,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_stall,
	output logic [ffra_pkg::STAT_BITS-1:0]        status,
	output logic [ADDR_BITS-1:0]                  addr
);
	import ffra_pkg::*;

	localparam int unsigned SW = $clog2(SLOTS);
	localparam int unsigned HW = $clog2(HOLES);
	localparam int unsigned CW = $clog2(HOLES + 1);
	localparam int unsigned AW = ADDR_BITS;

	// latched request
	logic                 cmd_q;
	logic [RID_BITS-1:0]  rid_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 vld_q;

	// working registers
	logic [AW-1:0] ss_q, se_q, hs_q, he_q;
	logic [CW-1:0] k_q, cnt_q;
	logic [AW-1:0] bp_q;
	logic [LIMIT_BITS-1:0] limit_q;
	logic [SLOTS-1:0] slot_vld_q;
	status_t status_q;
	logic [AW-1:0] addr_q;

	// result register
	logic          rsp_valid_q;
	status_t       rsp_status_q;
	logic [AW-1:0] rsp_addr_q;

	logic [31:0]   rid_in_ext, rid_q_ext;
	logic [SW-1:0] rd_slot, wr_slot;
	logic [AW-1:0] size_a, len;
	logic [CW-1:0] km1, kp1;

	logic            slot_we;
	logic [2*AW-1:0] slot_wdata, slot_rdata;
	logic            hole_we;
	logic [HW-1:0]   hole_waddr, hole_raddr;
	logic [2*AW-1:0] hole_wdata, hole_rdata;
	logic            out_load;

	assign rid_in_ext = 32'(region_id);
	assign rid_q_ext  = 32'(rid_q);
	assign rd_slot    = rid_in_ext[SW-1:0];
	assign wr_slot    = rid_q_ext[SW-1:0];
	assign size_a     = AW'(size_q);
	assign len        = he_q - hs_q;
	assign km1        = k_q - CW'(1);
	assign kp1        = k_q + CW'(1);

	assign req_stall = (op != A_ACCEPT);
	assign out_load  = (op == A_EMIT) && !(rsp_valid_q && rsp_stall);

	always_comb begin
		flags.no_req   = !req_valid;
		flags.bad_slot = rid_q_ext >= 32'(SLOTS);
		flags.is_free  = (cmd_q == CMD_FREE);
		flags.k_zero   = (k_q == '0);
		flags.no_fit   = 32'(len) < 32'(size_q);
		flags.exact    = 32'(len) == 32'(size_q);
		flags.sh_end   = kp1 >= cnt_q;
		flags.over     = (34'(bp_q) + 34'(size_q)) > 34'(limit_q);
		flags.empty    = ss_q >= se_q;
		flags.full     = cnt_q >= CW'(HOLES);
		flags.out_busy = rsp_valid_q && rsp_stall;
	end

	// slot table write port
	always_comb begin
		slot_we    = 1'b0;
		slot_wdata = {hs_q, hs_q + size_a};
		unique case (op)
			A_GRANT_HOLE: begin
				slot_we    = 1'b1;
				slot_wdata = {hs_q, hs_q + size_a};
			end
			A_GROW: begin
				slot_we    = 1'b1;
				slot_wdata = {bp_q, bp_q + size_a};
			end
			default: begin
				slot_we = 1'b0;
			end
		endcase
	end

	// hole list ports
	always_comb begin
		hole_we    = 1'b0;
		hole_waddr = k_q[HW-1:0];
		hole_wdata = hole_rdata;
		hole_raddr = km1[HW-1:0];
		unique case (op)
			A_SPLIT: begin
				hole_we    = 1'b1;
				hole_wdata = {hs_q + size_a, he_q};
			end
			A_SHIFT_RD: begin
				hole_raddr = kp1[HW-1:0];
			end
			A_SHIFT_WR: begin
				hole_we = 1'b1;
			end
			A_PUSH: begin
				hole_we    = 1'b1;
				hole_waddr = cnt_q[HW-1:0];
				hole_wdata = {ss_q, se_q};
			end
			default: begin
				hole_we = 1'b0;
			end
		endcase
	end

	ffra_ram #(.WIDTH(2 * AW), .DEPTH(SLOTS)) u_slot_ram (
		.clk     (clk),
		.wr_en   (slot_we),
		.wr_addr (wr_slot),
		.wr_data (slot_wdata),
		.rd_addr (rd_slot),
		.rd_data (slot_rdata)
	);

	ffra_ram #(.WIDTH(2 * AW), .DEPTH(HOLES)) u_hole_ram (
		.clk     (clk),
		.wr_en   (hole_we),
		.wr_addr (hole_waddr),
		.wr_data (hole_wdata),
		.rd_addr (hole_raddr),
		.rd_data (hole_rdata)
	);

	// payload and scratch registers
	always_ff @(posedge clk) begin
		unique case (op)
			A_ACCEPT: begin
				cmd_q  <= cmd;
				rid_q  <= region_id;
				size_q <= size;
				vld_q  <= slot_vld_q[rd_slot];
			end
			A_LOAD_SLOT: begin
				ss_q     <= vld_q ? slot_rdata[2*AW-1:AW] : '0;
				se_q     <= vld_q ? slot_rdata[AW-1:0] : '0;
				k_q      <= cnt_q;
				status_q <= ST_BAD_SLOT;
				addr_q   <= '0;
			end
			A_HOLE_LOAD: begin
				hs_q <= hole_rdata[2*AW-1:AW];
				he_q <= hole_rdata[AW-1:0];
				k_q  <= km1;
			end
			A_GRANT_HOLE: begin
				status_q <= ST_OK;
				addr_q   <= hs_q;
			end
			A_SHIFT_WR: begin
				k_q <= kp1;
			end
			A_LIMIT: begin
				status_q <= ST_LIMIT;
				addr_q   <= '0;
			end
			A_GROW: begin
				status_q <= ST_OK;
				addr_q   <= bp_q;
			end
			A_EMPTY: begin
				status_q <= ST_EMPTY;
				addr_q   <= '0;
			end
			A_FULL: begin
				status_q <= ST_FULL;
				addr_q   <= '0;
			end
			A_PUSH: begin
				status_q <= ST_OK;
				addr_q   <= '0;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			rsp_status_q <= status_q;
			rsp_addr_q   <= addr_q;
		end
	end

	// allocator state and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			bp_q        <= '0;
			limit_q     <= '1;
			slot_vld_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			unique case (op)
				A_GRANT_HOLE: slot_vld_q[wr_slot] <= 1'b1;
				A_GROW: begin
					bp_q                <= bp_q + size_a;
					slot_vld_q[wr_slot] <= 1'b1;
				end
				A_DROP: cnt_q <= cnt_q - CW'(1);
				A_PUSH: begin
					cnt_q               <= cnt_q + CW'(1);
					slot_vld_q[wr_slot] <= 1'b0;
				end
				default: begin
				end
			endcase
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = rsp_status_q;
	assign addr      = rsp_addr_q;
endmodule
`default_nettype wire
